// ----- rtl/bdq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  // item field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // where the new value of a physical end comes from
  typedef enum logic [1:0] {
    SRC_KEEP = 2'd0,
    SRC_WORD = 2'd1,
    SRC_RAM  = 2'd2
  } src_e;

  typedef logic signed [DATA_W-1:0] word_t;

  // per-item control passed from the pointer stage to the result stage
  typedef struct packed {
    src_e    first_src;
    src_e    last_src;
    logic    rev;
    status_e status;
  } stage_info_t;

endpackage

`default_nettype wire

// ----- rtl/bdq_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// command channel
interface bdq_in_if;
  import bdq_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// result channel
interface bdq_out_if #(
  parameter int unsigned CNT_W = 5
);
  import bdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [CNT_W-1:0]         count;
  logic                     is_full;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output front_value, output back_value, output count,
                  output is_full, output status, input ready);
  modport sink   (input valid, input front_value, input back_value, input count,
                  input is_full, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/bdq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/bdq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command side
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [bdq_pkg::OP_W-1:0]      op_i,
  input  wire bdq_pkg::word_t                value_i,
  // to result stage
  output      logic                          s2_valid_o,
  input  wire logic                          s2_ready_i,
  output      bdq_pkg::stage_info_t          s2_info_o,
  output      logic [$clog2(DEPTH+1)-1:0]    s2_cnt_o,
  output      bdq_pkg::word_t                s2_value_o,
  // slot store access
  output      logic                          ram_we_o,
  output      logic [$clog2(DEPTH)-1:0]      ram_waddr_o,
  output      bdq_pkg::word_t                ram_wdata_o,
  output      logic                          ram_re_o,
  output      logic [$clog2(DEPTH)-1:0]      ram_raddr_o
);
  import bdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  // circular index helpers
  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] x);
    logic [AW-1:0] r;
    r = (x == AW'(DEPTH - 1)) ? '0 : x + AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] x);
    logic [AW-1:0] r;
    r = (x == '0) ? AW'(DEPTH - 1) : x - AW'(1);
    return r;
  endfunction

  // input register
  logic              s1_valid_q;
  logic [OP_W-1:0]   s1_op_q;
  word_t             s1_value_q;

  // pointer state
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              rev_q, rev_d;

  // stage register towards the result stage
  logic              s2_valid_q;
  stage_info_t       s2_info_q, s2_info_d;
  logic [CW-1:0]     s2_cnt_q;
  word_t             s2_value_q;

  logic              s2_free;
  logic              s1_go;
  logic              full;
  logic              empty;
  logic              at_head_push;
  logic              at_head_pop;
  logic [SW-1:0]     tail_sum;
  logic [AW-1:0]     tail_free;
  logic [AW-1:0]     prev_last;
  logic [AW-1:0]     head_dec;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;

  assign s2_free    = !s2_valid_q || s2_ready_i;
  assign s1_go      = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s1_go;

  // physical end addresses
  assign full         = (cnt_q == CW'(DEPTH));
  assign empty        = (cnt_q == '0);
  assign at_head_push = (s1_op_q == OP_PUSH_FRONT) != rev_q;
  assign at_head_pop  = (s1_op_q == OP_POP_FRONT) != rev_q;
  assign tail_sum     = SW'(head_q) + SW'(cnt_q);
  assign tail_free    = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                                 : tail_sum[AW-1:0];
  assign prev_last    = idx_dec(idx_dec(tail_free));
  assign head_dec     = idx_dec(head_q);

  // operation decode and next pointer state
  always_comb begin
    head_d              = head_q;
    cnt_d               = cnt_q;
    rev_d               = rev_q;
    we                  = 1'b0;
    waddr               = tail_free;
    raddr               = idx_inc(head_q);
    s2_info_d.first_src = SRC_KEEP;
    s2_info_d.last_src  = SRC_KEEP;
    s2_info_d.status    = ST_DONE;
    unique case (s1_op_q)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          s2_info_d.status = ST_FULL;
        end else begin
          cnt_d = cnt_q + CW'(1);
          we    = 1'b1;
          if (at_head_push) begin
            head_d              = head_dec;
            waddr               = head_dec;
            s2_info_d.first_src = SRC_WORD;
            s2_info_d.last_src  = empty ? SRC_WORD : SRC_KEEP;
          end else begin
            s2_info_d.last_src  = SRC_WORD;
            s2_info_d.first_src = empty ? SRC_WORD : SRC_KEEP;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          s2_info_d.status = ST_EMPTY;
        end else begin
          cnt_d = cnt_q - CW'(1);
          if (at_head_pop) begin
            head_d              = idx_inc(head_q);
            s2_info_d.first_src = SRC_RAM;
          end else begin
            raddr               = prev_last;
            s2_info_d.last_src  = SRC_RAM;
          end
        end
      end
      OP_REVERSE: begin
        if (empty) begin
          s2_info_d.status = ST_EMPTY;
        end else begin
          rev_d = !rev_q;
        end
      end
      default: begin
      end
    endcase
    s2_info_d.rev = rev_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      head_q     <= '0;
      cnt_q      <= '0;
      rev_q      <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        s2_valid_q <= 1'b1;
        head_q     <= head_d;
        cnt_q      <= cnt_d;
        rev_q      <= rev_d;
      end else if (s2_ready_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q    <= op_i;
      s1_value_q <= value_i;
    end
    if (s1_go) begin
      s2_info_q  <= s2_info_d;
      s2_cnt_q   <= cnt_d;
      s2_value_q <= s1_value_q;
    end
  end

  assign s2_valid_o  = s2_valid_q;
  assign s2_info_o   = s2_info_q;
  assign s2_cnt_o    = s2_cnt_q;
  assign s2_value_o  = s2_value_q;

  assign ram_we_o    = s1_go && we;
  assign ram_waddr_o = waddr;
  assign ram_wdata_o = s1_value_q;
  assign ram_re_o    = s1_go;
  assign ram_raddr_o = raddr;

endmodule

`default_nettype wire

// ----- rtl/bdq_result.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bdq_result #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // from pointer stage
  input  wire logic                               s2_valid_i,
  output      logic                               s2_ready_o,
  input  wire bdq_pkg::stage_info_t               s2_info_i,
  input  wire logic [$clog2(DEPTH+1)-1:0]         s2_cnt_i,
  input  wire bdq_pkg::word_t                     s2_value_i,
  input  wire bdq_pkg::word_t                     ram_rdata_i,
  // result side
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      bdq_pkg::word_t                     front_o,
  output      bdq_pkg::word_t                     back_o,
  output      logic [$clog2(DEPTH+1)-1:0]         count_o,
  output      logic                               full_o,
  output      logic [bdq_pkg::STATUS_W-1:0]       status_o
);
  import bdq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // values at the physical ends
  word_t             first_q, first_d;
  word_t             last_q, last_d;

  logic              out_valid_q;
  word_t             front_q, front_d;
  word_t             back_q, back_d;
  logic [CW-1:0]     cnt_q;
  logic              full_q;
  status_e           status_q;
  logic              s2_go;

  assign s2_ready_o = !out_valid_q || out_ready_i;
  assign s2_go      = s2_valid_i && s2_ready_o;

  // pick the new end values
  always_comb begin
    case (s2_info_i.first_src)
      SRC_WORD: first_d = s2_value_i;
      SRC_RAM:  first_d = ram_rdata_i;
      default:  first_d = first_q;
    endcase
    case (s2_info_i.last_src)
      SRC_WORD: last_d = s2_value_i;
      SRC_RAM:  last_d = ram_rdata_i;
      default:  last_d = last_q;
    endcase
    if (s2_cnt_i == '0) begin
      front_d = '0;
      back_d  = '0;
    end else if (s2_info_i.rev) begin
      front_d = last_d;
      back_d  = first_d;
    end else begin
      front_d = first_d;
      back_d  = last_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // end values and result payload
  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      first_q  <= first_d;
      last_q   <= last_d;
      front_q  <= front_d;
      back_q   <= back_d;
      cnt_q    <= s2_cnt_i;
      full_q   <= (s2_cnt_i == CW'(DEPTH));
      status_q <= s2_info_i.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign front_o     = front_q;
  assign back_o      = back_q;
  assign count_o     = cnt_q;
  assign full_o      = full_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ----- rtl/bounded_deque_with_reverse.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of DEPTH signed 32-bit words. Each command item
// (push front, push back, pop front, pop back, reverse) yields one result item
// with the front and back words (0 when empty), the count, a full flag and a
// status: done, push dropped because full, or pop/reverse ignored because
// empty. Words sit in a circular slot RAM with a head pointer; reverse only
// flips a flag that swaps the physical ends, so every command takes the same
// path. One command is accepted every cycle unless the result side stalls; a
// result is offered once its command has passed the input register, the
// pointer stage register (loaded together with the RAM read of the new end
// after a pop) and the result register. The slot RAM needs no clearing after
// reset, so commands are taken straight away.
module bounded_deque_with_reverse #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bdq_in_if.sink     cmd_i,
  bdq_out_if.source  res_o
);
  import bdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic              s2_valid;
  logic              s2_ready;
  stage_info_t       s2_info;
  logic [CW-1:0]     s2_cnt;
  word_t             s2_value;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  word_t             ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  word_t             front;
  word_t             back;

  // pointer stage
  bdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .op_i        (cmd_i.operation),
    .value_i     (cmd_i.value),
    .s2_valid_o  (s2_valid),
    .s2_ready_i  (s2_ready),
    .s2_info_o   (s2_info),
    .s2_cnt_o    (s2_cnt),
    .s2_value_o  (s2_value),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  // slot store
  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result stage
  bdq_result #(
    .DEPTH (DEPTH)
  ) u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_valid_i  (s2_valid),
    .s2_ready_o  (s2_ready),
    .s2_info_i   (s2_info),
    .s2_cnt_i    (s2_cnt),
    .s2_value_i  (s2_value),
    .ram_rdata_i (word_t'(ram_rdata)),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .front_o     (front),
    .back_o      (back),
    .count_o     (res_o.count),
    .full_o      (res_o.is_full),
    .status_o    (res_o.status)
  );

  assign res_o.front_value = front;
  assign res_o.back_value  = back;

endmodule

`default_nettype wire
